[hw/rtl/aaat_pkg.sv]
// ----------------------------------------------------------------------------
// Axis-angle affine transform package
// Shared widths, register indexes, builder state type and the CORDIC table.
// ----------------------------------------------------------------------------
package aaat_pkg;

   localparam int CORDIC_STEPS     = 16;
   localparam int COORD_WIDTH      = 32;
   localparam int MATRIX_FRAC_BITS = 16;

   localparam int MAT_W        = MATRIX_FRAC_BITS + 4;
   localparam int AXIS_W       = 16;
   localparam int ANGLE_W      = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int STEP_W       = $clog2(CORDIC_ITERS);
   localparam int CORD_W       = 36;
   localparam int ACC_W        = 64;
   localparam int CSR_IDX_W    = 3;

   // Point datapath widths
   localparam int PROD_W = MAT_W + COORD_WIDTH;
   localparam int SUM_W  = PROD_W + 2;
   localparam int SH_W   = SUM_W - MATRIX_FRAC_BITS;
   localparam int RES_W  = SH_W + 1;

   localparam logic [CSR_IDX_W-1:0] REG_AXIS_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT_Z = 3'd6;

   typedef enum logic [2:0] {
      BLD_IDLE,
      BLD_START,
      BLD_ROTATE,
      BLD_FINISH,
      BLD_MUL1,
      BLD_MUL2,
      BLD_WRITE
   } bld_state_type;

   typedef struct packed {
      logic                    valid;
      logic [1:0]              row;
      logic [1:0]              col;
      logic signed [MAT_W-1:0] value;
   } mat_wr_type;

   // arctan(2^-i) in Q2.30, truncated
   function automatic logic signed [CORD_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [CORD_W-1:0] val;
      unique case (idx)
         5'd0:  val = 36'sd843314856;
         5'd1:  val = 36'sd497837829;
         5'd2:  val = 36'sd263043836;
         5'd3:  val = 36'sd133525158;
         5'd4:  val = 36'sd67021686;
         5'd5:  val = 36'sd33543515;
         5'd6:  val = 36'sd16775850;
         5'd7:  val = 36'sd8388437;
         5'd8:  val = 36'sd4194282;
         5'd9:  val = 36'sd2097149;
         5'd10: val = 36'sd1048575;
         5'd11: val = 36'sd524287;
         5'd12: val = 36'sd262143;
         5'd13: val = 36'sd131071;
         5'd14: val = 36'sd65535;
         5'd15: val = 36'sd32767;
         5'd16: val = 36'sd16383;
         5'd17: val = 36'sd8191;
         5'd18: val = 36'sd4095;
         5'd19: val = 36'sd2047;
         5'd20: val = 36'sd1023;
         5'd21: val = 36'sd511;
         5'd22: val = 36'sd255;
         5'd23: val = 36'sd127;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[hw/rtl/aaat_build.sv]
// ----------------------------------------------------------------------------
// Rotation matrix builder
// CORDIC sine/cosine, then the Rodrigues entries one at a time.
// ----------------------------------------------------------------------------
module aaat_build (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [aaat_pkg::AXIS_W-1:0]    axis_x,
   input  logic signed [aaat_pkg::AXIS_W-1:0]    axis_y,
   input  logic signed [aaat_pkg::AXIS_W-1:0]    axis_z,
   input  logic signed [aaat_pkg::ANGLE_W-1:0]   angle,
   output logic                                  busy,
   output aaat_pkg::mat_wr_type                  mat_wr
);
   import aaat_pkg::*;

   localparam logic signed [CORD_W-1:0] GAIN    = 36'sd652032874;
   localparam logic signed [ANGLE_W:0]  PI_Q13  = 17'sd25736;
   localparam logic signed [ANGLE_W:0]  HPI_Q13 = 17'sd12868;
   localparam logic signed [ACC_W-1:0]  RND     = ACC_W'(1) << (57 - MATRIX_FRAC_BITS);
   localparam logic signed [ACC_W-1:0]  LIM     = ACC_W'(1) << (MATRIX_FRAC_BITS + 3);

   bld_state_type state_ff, state_in;
   logic signed [CORD_W-1:0]   x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [CORD_W-1:0]   c_ff, c_in, s_ff, s_in;
   logic                       flip_ff, flip_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [1:0]                 row_ff, row_in, col_ff, col_in;
   logic signed [31:0]         p1_ff, p1_in;
   logic signed [CORD_W+AXIS_W-1:0] p2_ff, p2_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in, term_ff, term_in;

   logic signed [ANGLE_W:0]    ang, ang_f;
   logic signed [CORD_W-1:0]   dx, dy, v;
   logic signed [ACC_W-1:0]    sum, sh;
   logic                       add_term;

   function automatic logic signed [AXIS_W-1:0] pick(input logic [1:0] idx,
         input logic signed [AXIS_W-1:0] a0, input logic signed [AXIS_W-1:0] a1,
         input logic signed [AXIS_W-1:0] a2);
      logic signed [AXIS_W-1:0] r;
      unique case (idx)
         2'd0:    r = a0;
         2'd1:    r = a1;
         default: r = a2;
      endcase
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BLD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff <= x_in;  y_ff <= y_in;  z_ff <= z_in;
      c_ff <= c_in;  s_ff <= s_in;  flip_ff <= flip_in;
      step_ff <= step_in;  row_ff <= row_in;  col_ff <= col_in;
      p1_ff <= p1_in;  p2_ff <= p2_in;  acc_ff <= acc_in;  term_ff <= term_in;
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff;  y_in = y_ff;  z_in = z_ff;
      c_in = c_ff;  s_in = s_ff;  flip_in = flip_ff;
      step_in = step_ff;  row_in = row_ff;  col_in = col_ff;
      p1_in = p1_ff;  p2_in = p2_ff;  acc_in = acc_ff;  term_in = term_ff;
      mat_wr = '0;

      ang = {angle[ANGLE_W-1], angle};
      if (ang > HPI_Q13) begin
         ang_f = ang - PI_Q13;
      end else if (ang < -HPI_Q13) begin
         ang_f = ang + PI_Q13;
      end else begin
         ang_f = ang;
      end
      dx = y_ff >>> step_ff;
      dy = x_ff >>> step_ff;
      v  = (CORD_W'(1) <<< 30) - c_ff;
      add_term = (row_ff == 2'd0 && col_ff == 2'd2) || (row_ff == 2'd1 && col_ff == 2'd0) ||
                 (row_ff == 2'd2 && col_ff == 2'd1);
      sum = acc_ff + term_ff + RND;
      sh  = sum >>> (58 - MATRIX_FRAC_BITS);

      unique case (state_ff)
         BLD_IDLE: begin
         end
         BLD_START: begin
            flip_in  = (ang != ang_f);
            x_in     = GAIN;
            y_in     = '0;
            z_in     = CORD_W'(ang_f) <<< 17;
            step_in  = '0;
            state_in = BLD_ROTATE;
         end
         BLD_ROTATE: begin
            if (z_ff >= 0) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_q30(5'(step_ff));
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_q30(5'(step_ff));
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_ITERS - 1)) begin
               state_in = BLD_FINISH;
            end
         end
         BLD_FINISH: begin
            c_in     = flip_ff ? -x_ff : x_ff;
            s_in     = flip_ff ? -y_ff : y_ff;
            row_in   = '0;
            col_in   = '0;
            state_in = BLD_MUL1;
         end
         BLD_MUL1: begin
            p1_in = pick(row_ff, axis_x, axis_y, axis_z) * pick(col_ff, axis_x, axis_y, axis_z);
            p2_in = pick(2'd3 - row_ff - col_ff, axis_x, axis_y, axis_z) * s_ff;
            state_in = BLD_MUL2;
         end
         BLD_MUL2: begin
            acc_in = p1_ff * v;
            if (row_ff == col_ff) begin
               term_in = ACC_W'(c_ff) <<< 28;
            end else if (add_term) begin
               term_in = ACC_W'(p2_ff) <<< 14;
            end else begin
               term_in = -(ACC_W'(p2_ff) <<< 14);
            end
            state_in = BLD_WRITE;
         end
         BLD_WRITE: begin
            mat_wr.valid = 1'b1;
            mat_wr.row   = row_ff;
            mat_wr.col   = col_ff;
            if (sh < -LIM) begin
               mat_wr.value = MAT_W'(-LIM);
            end else if (sh > LIM - 1) begin
               mat_wr.value = MAT_W'(LIM - 1);
            end else begin
               mat_wr.value = MAT_W'(sh);
            end
            state_in = BLD_MUL1;
            if (col_ff == 2'd2) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
               if (row_ff == 2'd2) begin
                  state_in = BLD_IDLE;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         default: state_in = BLD_IDLE;
      endcase

      // restart on any axis or angle write
      if (start) begin
         state_in = BLD_START;
      end
   end

   assign busy = (state_ff != BLD_IDLE);

endmodule

[hw/rtl/axis_angle_affine_transform.sv]
// ----------------------------------------------------------------------------
// Axis-angle affine transform
// Rotates each Q16.16 point by a Rodrigues matrix and adds a translation.
// ----------------------------------------------------------------------------
// Throughput is one point per clock while the output is not stalled and no matrix
// rebuild is running; the stages are multiply, row sum and round, translate, and
// saturate into the output register. A write to an axis or angle register starts
// a matrix rebuild in a shared sequencer: a start step, the 16 CORDIC iterations,
// a step to fix the signs, then for each of the nine entries two multiplies and a
// round/saturate. req_tready stays low for the whole rebuild.
// Translation writes take effect at once. Write configuration only while no
// transaction is in flight. The axis is used as written, without normalizing.
module axis_angle_affine_transform (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [3*aaat_pkg::COORD_WIDTH-1:0]    req_tdata,  // point_x, point_y, point_z
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [3*aaat_pkg::COORD_WIDTH-1:0]    rsp_tdata,  // moved_x, moved_y, moved_z
   output logic                                  rsp_tuser,  // clipped
   input  logic                                  csr_we,
   input  logic [aaat_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [aaat_pkg::COORD_WIDTH-1:0]      csr_wdata
);
   import aaat_pkg::*;

   localparam int C = COORD_WIDTH;
   localparam logic signed [SUM_W-1:0] PT_RND = SUM_W'(1) << (MATRIX_FRAC_BITS - 1);
   localparam logic signed [RES_W-1:0] RES_LO = -(RES_W'(1) << (C - 1));
   localparam logic signed [RES_W-1:0] RES_HI = (RES_W'(1) << (C - 1)) - 1;

   // Configuration registers
   logic signed [AXIS_W-1:0]  axis_x_ff, axis_y_ff, axis_z_ff;
   logic signed [ANGLE_W-1:0] angle_ff;
   logic signed [C-1:0]       shift_ff [3];
   logic                      start;

   // Matrix, row major
   logic signed [MAT_W-1:0]   mat_ff [9];
   logic [3:0]                mat_idx;
   mat_wr_type                mat_wr;
   logic                      busy;

   // Pipeline
   logic                      v1_ff, v2_ff, v3_ff;
   logic                      adv1, adv2, adv3, adv4;
   logic signed [C-1:0]       pt [3];
   logic signed [PROD_W-1:0]  prod_ff [9];
   logic signed [SH_W-1:0]    rot_ff [3];
   logic signed [RES_W-1:0]   res_ff [3];
   logic signed [SUM_W-1:0]   row_sum [3];
   logic signed [C-1:0]       moved [3];
   logic [2:0]                hit;

   assign start = csr_we && (csr_index == REG_AXIS_X || csr_index == REG_AXIS_Y ||
                             csr_index == REG_AXIS_Z || csr_index == REG_ANGLE);

   // Hold configuration; ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_x_ff <= '0;
         axis_y_ff <= '0;
         axis_z_ff <= AXIS_W'(16384);
         angle_ff  <= '0;
         for (int i = 0; i < 3; i++) begin
            shift_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            REG_AXIS_X:  axis_x_ff   <= csr_wdata[AXIS_W-1:0];
            REG_AXIS_Y:  axis_y_ff   <= csr_wdata[AXIS_W-1:0];
            REG_AXIS_Z:  axis_z_ff   <= csr_wdata[AXIS_W-1:0];
            REG_ANGLE:   angle_ff    <= csr_wdata[ANGLE_W-1:0];
            REG_SHIFT_X: shift_ff[0] <= csr_wdata;
            REG_SHIFT_Y: shift_ff[1] <= csr_wdata;
            REG_SHIFT_Z: shift_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   aaat_build u_build (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .axis_x (axis_x_ff),
      .axis_y (axis_y_ff),
      .axis_z (axis_z_ff),
      .angle  (angle_ff),
      .busy   (busy),
      .mat_wr (mat_wr)
   );

   // Reset to identity; the builder overwrites one entry per write cycle
   assign mat_idx = ({2'b00, mat_wr.row} * 4'd3) + {2'b00, mat_wr.col};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            mat_ff[i] <= (i % 4 == 0) ? (MAT_W'(1) << MATRIX_FRAC_BITS) : '0;
         end
      end else if (mat_wr.valid) begin
         mat_ff[mat_idx] <= mat_wr.value;
      end
   end

   // Each stage advances when empty or when the next one moves; bubbles collapse
   assign adv4 = !rsp_tvalid || rsp_tready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_tready = adv1 && !busy;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         pt[j] = req_tdata[j*C +: C];
      end
      for (int r = 0; r < 3; r++) begin
         row_sum[r] = SUM_W'(prod_ff[r*3]) + SUM_W'(prod_ff[r*3+1]) + SUM_W'(prod_ff[r*3+2])
                      + PT_RND;
      end
      for (int r = 0; r < 3; r++) begin
         if (res_ff[r] < RES_LO) begin
            moved[r] = C'(RES_LO);
            hit[r]   = 1'b1;
         end else if (res_ff[r] > RES_HI) begin
            moved[r] = C'(RES_HI);
            hit[r]   = 1'b1;
         end else begin
            moved[r] = C'(res_ff[r]);
            hit[r]   = 1'b0;
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         rsp_tvalid <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_tvalid && req_tready;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) rsp_tvalid <= v3_ff;
      end
   end

   // Payload: multiply, sum and round, translate, saturate
   always_ff @(posedge clock) begin
      if (adv1) begin
         for (int i = 0; i < 9; i++) begin
            prod_ff[i] <= mat_ff[i] * pt[i % 3];
         end
      end
      if (adv2) begin
         for (int r = 0; r < 3; r++) begin
            rot_ff[r] <= SH_W'(row_sum[r] >>> MATRIX_FRAC_BITS);
         end
      end
      if (adv3) begin
         for (int r = 0; r < 3; r++) begin
            res_ff[r] <= RES_W'(rot_ff[r]) + RES_W'(shift_ff[r]);
         end
      end
      if (adv4) begin
         rsp_tdata <= {moved[2], moved[1], moved[0]};
         rsp_tuser <= |hit;
      end
   end

endmodule

[hw/rtl/aaat_check.sv]
// ----------------------------------------------------------------------------
// Axis-angle affine transform checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module aaat_check (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic [3*aaat_pkg::COORD_WIDTH-1:0]    req_tdata,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [3*aaat_pkg::COORD_WIDTH-1:0]    rsp_tdata,
   input  logic                                  rsp_tuser,
   input  logic                                  csr_we,
   input  logic [aaat_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [aaat_pkg::COORD_WIDTH-1:0]      csr_wdata
);
   import aaat_pkg::*;

   // No transaction comes out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Axis or angle write blocks input while the matrix rebuilds
   a_rebuild_block: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == REG_AXIS_X || csr_index == REG_AXIS_Y ||
                 csr_index == REG_AXIS_Z || csr_index == REG_ANGLE) |=> !req_tready)
      else $error("input taken during matrix rebuild");

   // A rebuild started by an angle write does not end too early
   a_rebuild_len: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == REG_ANGLE ##1 !csr_we |=> !req_tready)
      else $error("matrix rebuild ended too early");

endmodule

bind axis_angle_affine_transform aaat_check u_aaat_check (.*);

[test/axis_angle_affine_transform_test.sv]
// ----------------------------------------------------------------------------
// Axis-angle affine transform testbench
// Drives points through the block under several axis, angle and translation
// settings and checks every transformed point against an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_angle_affine_transform_test;
   import aaat_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [CW-1:0] z;
      logic [CW-1:0] y;
      logic [CW-1:0] x;
   } point_type;

   typedef struct {
      point_type pt;
      logic      clip;
   } moved_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [3*CW-1:0] req_tdata = '0;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [3*CW-1:0] rsp_tdata;
   logic            rsp_tuser;
   logic            csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CW-1:0]   csr_wdata = '0;

   // predictor state
   logic [15:0]   axis_reg [3];
   logic [15:0]   angle_reg;
   logic [CW-1:0] shift_reg [3];
   longint        rot_mat [9];
   bit            mat_fresh;

   moved_type expected_points [$];
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        mismatches = 0;
   int        points_checked = 0;
   int        clipped_seen = 0;
   longint    cycles = 0;

   axis_angle_affine_transform DUT (.*);

   always #4 clock = ~clock;

   // floor shift, matching arithmetic right shift on negatives
   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void rebuild_rotation();
      longint n [3];
      longint a, x, y, zz, c, s, v, lim, acc, term, dx, dy;
      bit flip;
      n[0] = longint'($signed(axis_reg[0]));
      n[1] = longint'($signed(axis_reg[1]));
      n[2] = longint'($signed(axis_reg[2]));
      a = longint'($signed(angle_reg));
      flip = 0;
      if (a > 12868) begin
         a -= 25736; flip = 1;
      end else if (a < -12868) begin
         a += 25736; flip = 1;
      end
      zz = a * 131072;
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (zz >= 0) begin
            x -= dx; y += dy; zz -= longint'(atan_q30(i[4:0]));
         end else begin
            x += dx; y -= dy; zz += longint'(atan_q30(i[4:0]));
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
      v = (longint'(1) << 30) - c;
      lim = longint'(1) << (MATRIX_FRAC_BITS + 3);
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            acc = n[r] * n[k] * v;
            if (r == k) begin
               acc += c * (longint'(1) << 28);
            end else begin
               term = n[3 - r - k] * s * 16384;
               if ((k - r + 3) % 3 == 2) acc += term;
               else acc -= term;
            end
            acc = floor_shr(acc + (longint'(1) << (57 - MATRIX_FRAC_BITS)),
                            58 - MATRIX_FRAC_BITS);
            if (acc < -lim) acc = -lim;
            if (acc > lim - 1) acc = lim - 1;
            rot_mat[r * 3 + k] = acc;
         end
      end
   endfunction

   function automatic moved_type transform_point(point_type p);
      moved_type m;
      longint ph [3], pl [3], pv, h, l, res, lo, hi;
      logic [CW-1:0] coord [3];
      logic [CW-1:0] outc [3];
      if (!mat_fresh) begin
         rebuild_rotation();
         mat_fresh = 1;
      end
      coord[0] = p.x; coord[1] = p.y; coord[2] = p.z;
      for (int j = 0; j < 3; j++) begin
         pv = longint'($signed(coord[j]));
         ph[j] = floor_shr(pv, 24);
         pl[j] = pv - ph[j] * (longint'(1) << 24);
      end
      lo = -(longint'(1) << (CW - 1));
      hi = (longint'(1) << (CW - 1)) - 1;
      m.clip = 0;
      for (int r = 0; r < 3; r++) begin
         h = 0; l = 0;
         for (int j = 0; j < 3; j++) begin
            h += rot_mat[r * 3 + j] * ph[j];
            l += rot_mat[r * 3 + j] * pl[j];
         end
         res = h * (longint'(1) << (24 - MATRIX_FRAC_BITS))
             + floor_shr(l + (longint'(1) << (MATRIX_FRAC_BITS - 1)), MATRIX_FRAC_BITS)
             + longint'($signed(shift_reg[r]));
         if (res < lo) begin
            res = lo; m.clip = 1;
         end else if (res > hi) begin
            res = hi; m.clip = 1;
         end
         outc[r] = res[CW-1:0];
      end
      m.pt.x = outc[0]; m.pt.y = outc[1]; m.pt.z = outc[2];
      return m;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d points pending", cycles,
                  expected_points.size());
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stall, compare each transaction with the oldest expectation
   always @(posedge clock) begin
      moved_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transaction %h", rsp_tdata);
            end else begin
               want = expected_points.pop_front();
               points_checked++;
               if (rsp_tuser) clipped_seen++;
               if (rsp_tdata[CW-1:0] !== want.pt.x || rsp_tdata[2*CW-1:CW] !== want.pt.y
                   || rsp_tdata[3*CW-1:2*CW] !== want.pt.z || rsp_tuser !== want.clip) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected x %h y %h z %h clip %b, got %h clip %b",
                              want.pt.x, want.pt.y, want.pt.z, want.clip, rsp_tdata,
                              rsp_tuser);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CW-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx < REG_SHIFT_X) begin
         if (idx == REG_ANGLE) angle_reg = val[15:0];
         else axis_reg[idx] = val[15:0];
         mat_fresh = 0;
      end else if (idx <= REG_SHIFT_Z) begin
         shift_reg[idx - REG_SHIFT_X] = val;
      end
   endtask

   // drop valid, hold until every expected point has come back, then let the pipe drain
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // present one point, hold it until accepted, then queue its prediction;
   // valid stays high into the next point unless the sender idles
   task automatic send_point(point_type p);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= p;
      do @(posedge clock); while (!req_tready);
      expected_points.push_back(transform_point(p));
   endtask

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(5))
         0: return {1'b0, {(CW-1){1'b1}}};
         1: return {1'b1, {(CW-1){1'b0}}};
         2: return CW'($signed($urandom_range(2000000)) - 1000000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(3))
         0: return 16'($signed($urandom_range(32768)) - 16384);
         1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
         default: return $urandom;
      endcase
   endfunction

   // directed table: reset matrix is identity with zero shift, so extremes
   // pass through unchanged
   typedef struct {
      point_type pt;
      bit        known;
      point_type want;
   } dir_row_type;

   dir_row_type directed [$];

   initial begin
      logic [CW-1:0] mx, mn;
      point_type p;
      int settings;
      mx = {1'b0, {(CW-1){1'b1}}};
      mn = {1'b1, {(CW-1){1'b0}}};
      axis_reg[0] = 0; axis_reg[1] = 0; axis_reg[2] = 16384; angle_reg = 0;
      for (int i = 0; i < 3; i++) shift_reg[i] = 0;
      for (int i = 0; i < 9; i++) rot_mat[i] = (i % 4 == 0) ? (longint'(1) << 16) : 0;
      mat_fresh = 1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back('{'{0, 0, 0}, 1, '{0, 0, 0}});
      directed.push_back('{'{mx, mn, mx}, 1, '{mx, mn, mx}});
      directed.push_back('{'{mn, mx, 32'h00010000}, 1, '{mn, mx, 32'h00010000}});
      directed.push_back('{'{32'hFFFFFFFF, 32'h1, 32'h00FFFFFF}, 1,
                           '{32'hFFFFFFFF, 32'h1, 32'h00FFFFFF}});
      foreach (directed[i]) send_point(directed[i].pt);
      drain();
      // every row's expectation was typed in; confirm the predictor agrees
      foreach (directed[i])
         if (directed[i].known && transform_point(directed[i].pt).pt !== directed[i].want) begin
            mismatches++;
            $display("predictor disagrees with identity row %0d", i);
         end

      // translation saturation, then a quarter turn, then extreme angles/axes
      write_csr(REG_SHIFT_X, mx);
      write_csr(REG_SHIFT_Y, mn);
      write_csr(REG_SHIFT_Z, 32'h00010000);
      send_point('{mx, mn, mx});
      send_point('{mn, mx, mn});
      send_point('{0, 0, 0});
      drain();
      write_csr(REG_ANGLE, 16'd12868);
      send_point('{32'h00010000, 32'h00020000, 32'hFFFF0000});
      send_point('{mx, mx, mx});
      drain();
      write_csr(REG_ANGLE, 16'h7FFF);
      write_csr(REG_AXIS_X, 16'h7FFF);
      write_csr(REG_AXIS_Y, 16'h8000);
      write_csr(REG_AXIS_Z, 16'h8000);
      send_point('{mn, mn, mn});
      send_point('{32'h12345678, 32'hFEDCBA98, 32'h00800000});
      drain();
      write_csr(REG_ANGLE, 16'h8000);
      send_point('{mx, 0, mn});
      drain();
      write_csr(REG_SHIFT_X, 0);
      write_csr(REG_SHIFT_Y, 0);
      write_csr(REG_SHIFT_Z, 0);

      // random phases: idling pattern advances every third of the run
      settings = 0;
      for (int ph = 0; ph < 30; ph++) begin
         if (ph == 10) begin
            send_idle_pct = 86; recv_idle_pct = 32;
         end else if (ph == 20) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end else if (ph == 0) begin
            send_idle_pct = 32; recv_idle_pct = 86;
         end
         drain();
         // retarget configuration between phases, extremes now and then
         write_csr(REG_AXIS_X, rand_axis());
         write_csr(REG_AXIS_Y, rand_axis());
         write_csr(REG_AXIS_Z, rand_axis());
         case ($urandom_range(3))
            0: write_csr(REG_ANGLE, $urandom_range(1) ? 16'sd25736 : -16'sd25736);
            1: write_csr(REG_ANGLE, $urandom);
            default: write_csr(REG_ANGLE, 16'($signed($urandom_range(51472)) - 25736));
         endcase
         for (int r = 0; r < 3; r++)
            write_csr(CSR_IDX_W'(REG_SHIFT_X + r), $urandom_range(2) == 0 ? rand_coord()
                                        : CW'($signed($urandom_range(8000000)) - 4000000));
         if (ph % 7 == 3) write_csr(3'd7, $urandom);  // unused index, ignored
         settings++;
         for (int k = 0; k < 61; k++) begin
            p.x = rand_coord(); p.y = rand_coord(); p.z = rand_coord();
            send_point(p);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("checked %0d points over %0d random settings, %0d clipped",
               points_checked, settings, clipped_seen);
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/aaat_pkg.sv
hw/rtl/aaat_build.sv
hw/rtl/axis_angle_affine_transform.sv
hw/rtl/aaat_check.sv
test/axis_angle_affine_transform_test.sv
